// ===== hdl/nsr_pkg.sv =====
// Shared constants and item class codes for the Newton square root unit.
package nsr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 31;
  localparam int QUEUE_DEPTH   = 4;
  localparam int ROOT_W        = 32;
  localparam int ITER_W        = 6;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd20;
  localparam logic [ROOT_W-1:0] ROOT_MAX   = 32'hFFFF_FFFF;

  // Class of an item in the queue
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NEG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POS  = 2'd2;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_NEG = 1'b1;

endpackage

// ===== hdl/nsr_front.sv =====
// Front end: accepts radicands, classifies them and queues them for the back end.
module nsr_front #(
  parameter int RAD_W = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [RAD_W-1:0]          radicand,
  output logic                      q_valid,
  output logic [nsr_pkg::KIND_W-1:0] q_kind,
  output logic [RAD_W-2:0]          q_value,
  input  logic                      q_pop
);
  import nsr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [KIND_W-1:0] kind_mem [QUEUE_DEPTH];
  logic [RAD_W-2:0]  val_mem  [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;
  logic [KIND_W-1:0] kind_in;

  assign busy    = (count == CNT_W'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign pop     = q_pop && (count != '0);
  assign q_valid = (count != '0);
  assign q_kind  = kind_mem[rd_ptr];
  assign q_value = val_mem[rd_ptr];

  // classify the incoming radicand
  always_comb begin
    if (radicand[RAD_W-1]) begin
      kind_in = KIND_NEG;
    end else if (radicand == '0) begin
      kind_in = KIND_ZERO;
    end else begin
      kind_in = KIND_POS;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr] <= kind_in;
      val_mem[wr_ptr]  <= radicand[RAD_W-2:0];
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/nsr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module nsr_div #(
  parameter int NUM_W = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import nsr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] den_r;
  logic [NUM_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quot[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  // datapath: quotient bits shift in as numerator bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (run) begin
      rem  <= fits ? NUM_W'(rem_sh - {1'b0, den_r}) : rem_sh[NUM_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/nsr_back.sv =====
// Back end: runs the Newton steps for one queued item and drives the result.
module nsr_back #(
  parameter int RAD_W     = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [nsr_pkg::ITER_W-1:0]  iter_count,
  input  logic                        q_valid,
  input  logic [nsr_pkg::KIND_W-1:0]  q_kind,
  input  logic [RAD_W-2:0]            q_value,
  output logic                        q_pop,
  output logic                        done,
  output logic [nsr_pkg::ROOT_W-1:0]  root,
  output logic                        status
);
  import nsr_pkg::*;

  localparam int NUM_W = RAD_W - 1 + FRAC_BITS;
  localparam int CMP_W = NUM_W + ROOT_W;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic              state;
  logic [NUM_W-1:0]  est;
  logic [NUM_W-1:0]  num;
  logic [ITER_W-1:0] iter_left;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  quot;
  logic [NUM_W-1:0]  est_upd;
  logic [NUM_W-1:0]  est_in;
  logic [NUM_W-1:0]  sat_src;
  logic [CMP_W-1:0]  sat_ext;
  logic [ROOT_W-1:0] root_sat;

  nsr_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (est),
    .done  (div_done),
    .quot  (quot)
  );

  assign q_pop  = (state == ST_IDLE) && q_valid;
  assign est_in = NUM_W'(q_value);

  // one Newton step: average of estimate and quotient, no carry out
  assign est_upd = (est >> 1) + (quot >> 1) + NUM_W'(est[0] & quot[0]);

  // saturate the root to its field
  assign sat_src  = (state == ST_IDLE) ? est_in : est_upd;
  assign sat_ext  = CMP_W'(sat_src);
  assign root_sat = (sat_ext > CMP_W'(ROOT_MAX)) ? ROOT_MAX : sat_ext[ROOT_W-1:0];

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
      done      <= 1'b0;
      iter_left <= '0;
    end else begin
      div_start <= 1'b0;
      done      <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_kind)
              KIND_NEG: begin
                done   <= 1'b1;
                root   <= '0;
                status <= STATUS_NEG;
              end
              KIND_POS: begin
                if (iter_count == '0) begin
                  done   <= 1'b1;
                  root   <= root_sat;
                  status <= STATUS_OK;
                end else begin
                  est       <= est_in;
                  num       <= {q_value, {FRAC_BITS{1'b0}}};
                  iter_left <= iter_count;
                  div_start <= 1'b1;
                  state     <= ST_DIV;
                end
              end
              default: begin
                done   <= 1'b1;
                root   <= '0;
                status <= STATUS_OK;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (iter_left == ITER_W'(1)) begin
              done   <= 1'b1;
              root   <= root_sat;
              status <= STATUS_OK;
              state  <= ST_IDLE;
            end else begin
              est       <= est_upd;
              iter_left <= iter_left - 1'b1;
              div_start <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/newton_square_root_unit.sv =====
// Top level of the Newton-Raphson square root unit.
// A radicand is taken on start while busy is low and placed in a four-item
// queue, so new items are taken while an earlier one is being refined. A
// negative or zero radicand, or a zero step count, yields its result when the
// idle back end pops it from the queue, via the queue entry and the registered
// done, root and status outputs. For a positive radicand each Newton step waits
// on the bit-serial divider, which produces one quotient bit per cycle. busy is
// high while the queue is full. Each result shows on root and status for
// exactly one cycle with done high; the receiver must take it then.
// iteration_count is written over the cfg channel, which is always ready;
// write it only while no item is in flight.
module newton_square_root_unit #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = nsr_pkg::INT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [INT_BITS+FRAC_BITS:0]   radicand,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nsr_pkg::ITER_W-1:0]    cfg_data,
  output logic                          done,
  output logic [nsr_pkg::ROOT_W-1:0]    root,
  output logic                          status
);
  import nsr_pkg::*;

  localparam int RAD_W = INT_BITS + FRAC_BITS + 1;

  logic [ITER_W-1:0] iteration_count;
  logic              q_valid;
  logic [KIND_W-1:0] q_kind;
  logic [RAD_W-2:0]  q_value;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  // step count register
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iteration_count <= cfg_data;
    end
  end

  nsr_front #(.RAD_W(RAD_W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .radicand (radicand),
    .q_valid  (q_valid),
    .q_kind   (q_kind),
    .q_value  (q_value),
    .q_pop    (q_pop)
  );

  nsr_back #(.RAD_W(RAD_W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .iter_count (iteration_count),
    .q_valid    (q_valid),
    .q_kind     (q_kind),
    .q_value    (q_value),
    .q_pop      (q_pop),
    .done       (done),
    .root       (root),
    .status     (status)
  );

  // a rejected radicand always reports a zero root
  a_neg_zero_root: assert property (@(posedge clk) disable iff (rst)
    done && (status == STATUS_NEG) |-> root == '0)
    else $error("negative radicand with nonzero root");

  // the back end only takes items that are queued
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a negative radicand comes back flagged the cycle after it is popped
  a_neg_flag: assert property (@(posedge clk) disable iff (rst)
    q_pop && (q_kind == KIND_NEG) |=> done && (status == STATUS_NEG))
    else $error("negative item not flagged");

endmodule

// ===== bench/tb_newton_square_root_unit.sv =====
// Testbench for the Newton square root unit: directed and random radicands checked against a predictor.
`timescale 1ns / 1ps

module tb_newton_square_root_unit;
  import nsr_pkg::*;

  localparam int RAD_W = INT_BITS_DEF + FRAC_BITS_DEF + 1;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              status;
  } root_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [RAD_W-1:0]  radicand = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ITER_W-1:0] cfg_data = '0;
  logic              done;
  logic [ROOT_W-1:0] root;
  logic              status;

  root_result_t      pending_roots[$];
  logic [ITER_W-1:0] step_count = ITER_RESET;
  int                err_cnt = 0;
  int                idle_pct = 0;

  newton_square_root_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .radicand  (radicand),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .root      (root),
    .status    (status)
  );

  always #1 clk = ~clk;

  // Newton refinement of one radicand at the given step count
  function automatic root_result_t predict_root(input logic [RAD_W-1:0] r,
                                                input logic [ITER_W-1:0] n);
    root_result_t res;
    logic [63:0]  num;
    logic [63:0]  est;
    logic [63:0]  quo;
    res.root   = '0;
    res.status = STATUS_OK;
    if (r[RAD_W-1]) begin
      res.status = STATUS_NEG;
    end else if (r != '0) begin
      num = {16'd0, r} << FRAC_BITS_DEF;
      est = {16'd0, r};
      for (int k = 0; k < n; k++) begin
        quo = (est == 0) ? '1 : num / est;
        est = (est >> 1) + (quo >> 1) + {63'd0, est[0] & quo[0]};
      end
      res.root = (est > {32'd0, ROOT_MAX}) ? ROOT_MAX : est[ROOT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Result checker: each strobed result against the oldest expectation
  always @(posedge clk) begin
    root_result_t want;
    if (!rst && done) begin
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected result root=%h status=%b", root, status));
      end else begin
        want = pending_roots.pop_front();
        if (root !== want.root)
          report_mismatch($sformatf("root %h, expected %h", root, want.root));
        if (status !== want.status)
          report_mismatch($sformatf("status %b, expected %b", status, want.status));
      end
    end
  end

  // Send one radicand, with random idle cycles first
  task automatic send_item(input logic [RAD_W-1:0] r);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    radicand = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_roots.push_back(predict_root(r, step_count));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_step_count(input logic [ITER_W-1:0] n);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    step_count = n;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [RAD_W-1:0] rand_radicand();
    logic [63:0] v;
    int          kind;
    v    = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind == 0) return v[RAD_W-1:0];
    if (kind == 1) return '0;
    if (kind == 2) return RAD_W'($urandom_range(70000));
    v[RAD_W-1] = 1'b0;
    return v[RAD_W-1:0] >> $urandom_range(RAD_W - 1);
  endfunction

  // Extremes, exact squares, negative and zero cases, step count extremes
  task automatic test_directed();
    logic [RAD_W-1:0] corners[10];
    corners = '{48'h0, 48'h1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
                48'h1_0000, 48'h4_0000, 48'h2_0000, 48'h9_0000, 48'h5555_AAAA_5555};
    idle_pct = 0;
    foreach (corners[i]) send_item(corners[i]);
    write_step_count(6'd63);
    send_item(48'h7FFF_FFFF_FFFF);
    send_item(48'h1);
    send_item(48'h0000_0001_0000);
    write_step_count(6'd0);
    send_item(48'h7FFF_FFFF_FFFF);
    send_item(48'h0000_1234_5678);
    send_item(48'h8000_0000_0001);
    send_item(48'h0);
    write_step_count(6'd1);
    send_item(48'h7FFF_FFFF_FFFF);
    send_item(48'h0000_0003_0000);
  endtask

  // Random radicands at one step count, cycling through idle modes
  task automatic test_random(input logic [ITER_W-1:0] n, input int count);
    write_step_count(n);
    for (int i = 0; i < count; i++) begin
      case ((i * 3) / count)
        0: idle_pct = 12;
        1: idle_pct = 76;
        default: idle_pct = 0;
      endcase
      send_item(rand_radicand());
    end
  endtask

  task automatic test_random_steps(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) write_step_count(ITER_W'($urandom_range(2, 8)));
      idle_pct = (i % 120 < 40) ? 76 : ((i % 120 < 80) ? 12 : 0);
      send_item(rand_radicand());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(6'd1, 400);
    test_random(6'd63, 12);
    test_random(6'd0, 250);
    test_random(6'd3, 380);
    test_random_steps(400);
    wait_idle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nsr_pkg.sv
hdl/nsr_front.sv
hdl/nsr_div.sv
hdl/nsr_back.sv
hdl/newton_square_root_unit.sv
bench/tb_newton_square_root_unit.sv
